@@ rtl/assert_macros.svh @@
// assertion helpers used by the checker module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is asserted
`define CHK_IMPLY(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
        else $error("check failed: implication");

// next-cycle implication, off while reset is asserted
`define CHK_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
        else $error("check failed: next-cycle implication");

`endif

@@ rtl/lca_pkg.sv @@
// ----------------------------------------------------------------------------
// lca_pkg
// Shared constants, types and helpers of the life rule stream stepper.
// ----------------------------------------------------------------------------
package lca_pkg;

    // largest grid side the line store holds
    localparam int MAX_WIDTH = 1024;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int CFG_W     = 11;

    // grid side after reset and the smallest usable side
    localparam int GRID_WIDTH_RESET = 64;
    localparam int MIN_WIDTH        = 3;

    // window bit of the cell under evaluation
    localparam int WIN_CENTRE = 4;

    // position flags carried from the accept stage to the update stage
    typedef struct packed {
        logic emit;
        logic interior;
        logic done;
    } lca_flags_t;

    // one result item
    typedef struct packed {
        logic out_valid;
        logic next_alive;
        logic cell_changed;
        logic frame_done;
        logic generation_stable;
    } lca_result_t;

    // live cells around the window centre
    function automatic logic [3:0] neighbour_count(input logic [8:0] win);
        logic [3:0] n;
        n = '0;
        for (int k = 0; k < 9; k++)
        begin
            if (k != WIN_CENTRE)
            begin
                n = n + {3'b000, win[k]};
            end
        end
        return n;
    endfunction

endpackage

@@ rtl/life_cellular_automaton_step.sv @@
// ----------------------------------------------------------------------------
// life_cellular_automaton_step
// One generation of the B3/S23 life rule over a raster-streamed square grid.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries one cell (cell_alive) per item in
//   raster order; the grid side W (outer dead ring included) comes from
//   cfg_wr_en/cfg_wr_data, clamped to 3..MAX_WIDTH, and a write restarts the
//   frame. Write it only while the block is idle.
//   Every input item gives one result item on result_valid/result_ready: the
//   next state of the cell W+1 positions back, with out_valid low for the
//   first W+1 items of a frame and border cells forced dead. frame_done marks
//   the result of the last cell, and generation_stable then tells whether no
//   cell changed in the generation.
//   Items pass the update stage register and the result queue to result_valid;
//   one item per cycle is sustained while the queue has room, set by the single
//   read and single write per cycle of the 2-bit line store RAM (read on
//   accept, write back next cycle). A 3-entry result queue absorbs receiver
//   stalls; in_ready drops only when the queue plus the item in flight would
//   overfill it. Reset clears the frame position, window and change flag and
//   sets W to 64. The line store has no clearing pass: every entry that
//   reaches an interior cell has been rewritten earlier in the same frame.
// ----------------------------------------------------------------------------
module life_cellular_automaton_step
    import lca_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    // configuration
    input  logic             cfg_wr_en,
    input  logic [CFG_W-1:0] cfg_wr_data,
    // input cells
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             cell_alive,
    // results
    output logic             result_valid,
    input  logic             result_ready,
    output logic             out_valid,
    output logic             next_alive,
    output logic             cell_changed,
    output logic             frame_done,
    output logic             generation_stable
);

    localparam int FIFO_DEPTH = 3;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    // frame position and grid size
    logic [COL_W-1:0] last_reg, last_next;
    logic [COL_W-1:0] row_reg, row_next;
    logic [COL_W-1:0] col_reg, col_next;

    // update stage
    logic             s1_v_reg;
    logic             s1_bit_reg;
    logic [COL_W-1:0] s1_col_reg;
    lca_flags_t       s1_flags_reg, flags_next;
    logic [8:0]       win_reg, win_next, win_new;
    logic             any_reg, any_next;

    // line store
    logic [1:0]       ls_rd;
    logic             up_bit, mid_bit;

    // result queue
    lca_result_t      fifo_reg [FIFO_DEPTH];
    lca_result_t      res_new;
    logic [PTR_W-1:0] head_reg, tail_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             accept, push, pop;
    logic [3:0]       ncount;
    logic             cur;

    assign accept = in_valid & in_ready;
    assign push   = s1_v_reg;
    assign pop    = result_valid & result_ready;

    // room for the item in flight plus a new one
    assign in_ready = ({1'b0, cnt_reg} + {{CNT_W{1'b0}}, s1_v_reg}) < (CNT_W + 1)'(FIFO_DEPTH);

    // clamped last index for a new grid side
    always_comb
    begin
        last_next = last_reg;
        if (cfg_wr_en)
        begin
            if (cfg_wr_data < CFG_W'(MIN_WIDTH))
            begin
                last_next = COL_W'(MIN_WIDTH - 1);
            end
            else if (32'(cfg_wr_data) > 32'(MAX_WIDTH))
            begin
                last_next = COL_W'(MAX_WIDTH - 1);
            end
            else
            begin
                last_next = COL_W'(cfg_wr_data - CFG_W'(1));
            end
        end
    end

    // position flags and raster advance at accept
    always_comb
    begin
        flags_next.emit     = (row_reg >= COL_W'(2)) ||
                              ((row_reg == COL_W'(1)) && (col_reg >= COL_W'(1)));
        flags_next.interior = (row_reg >= COL_W'(2)) && (col_reg >= COL_W'(2));
        flags_next.done     = (row_reg == last_reg) && (col_reg == last_reg);
        row_next = row_reg;
        col_next = col_reg;
        if (cfg_wr_en)
        begin
            row_next = '0;
            col_next = '0;
        end
        else if (accept)
        begin
            if (flags_next.done)
            begin
                row_next = '0;
                col_next = '0;
            end
            else if (col_reg == last_reg)
            begin
                col_next = '0;
                row_next = row_reg + COL_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    // line store: {upper, middle}; read on accept, written back next cycle.
    // consecutive items use distinct columns (W >= 3), so no forwarding
    lca_ram #(
        .WIDTH (2),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (s1_v_reg),
        .wr_addr (s1_col_reg),
        .wr_data ({mid_bit, s1_bit_reg}),
        .rd_en   (accept),
        .rd_addr (col_reg),
        .rd_data (ls_rd)
    );

    assign up_bit  = ls_rd[1];
    assign mid_bit = ls_rd[0];

    // window shift, rule and change tracking
    always_comb
    begin
        win_new = {win_reg[7], win_reg[6], s1_bit_reg, win_reg[4], win_reg[3],
                   mid_bit, win_reg[1], win_reg[0], up_bit};
        ncount  = neighbour_count(win_new);
        cur     = win_new[WIN_CENTRE];

        res_new.out_valid    = s1_flags_reg.emit;
        res_new.next_alive   = s1_flags_reg.interior &
                               ((ncount == 4'd3) | (cur & (ncount == 4'd2)));
        res_new.cell_changed = s1_flags_reg.interior & (res_new.next_alive ^ cur);
        res_new.frame_done   = s1_flags_reg.done;
        res_new.generation_stable = s1_flags_reg.done & ~(any_reg | res_new.cell_changed);

        win_next = win_reg;
        any_next = any_reg;
        if (cfg_wr_en)
        begin
            win_next = '0;
            any_next = 1'b0;
        end
        else if (s1_v_reg)
        begin
            win_next = s1_flags_reg.done ? 9'd0 : win_new;
            any_next = s1_flags_reg.done ? 1'b0 : (any_reg | res_new.cell_changed);
        end
    end

    // queue occupancy
    always_comb
    begin
        cnt_next = cnt_reg;
        case ({push, pop})
            2'b10:   cnt_next = cnt_reg + CNT_W'(1);
            2'b01:   cnt_next = cnt_reg - CNT_W'(1);
            default: cnt_next = cnt_reg;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg     <= COL_W'(GRID_WIDTH_RESET - 1);
            row_reg      <= '0;
            col_reg      <= '0;
            s1_v_reg     <= 1'b0;
            s1_flags_reg <= '0;
            win_reg      <= '0;
            any_reg      <= 1'b0;
            head_reg     <= '0;
            tail_reg     <= '0;
            cnt_reg      <= '0;
        end
        else
        begin
            last_reg <= last_next;
            row_reg  <= row_next;
            col_reg  <= col_next;
            s1_v_reg <= accept;
            if (accept)
            begin
                s1_flags_reg <= flags_next;
            end
            win_reg  <= win_next;
            any_reg  <= any_next;
            cnt_reg  <= cnt_next;
            if (push)
            begin
                tail_reg <= (tail_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : tail_reg + PTR_W'(1);
            end
            if (pop)
            begin
                head_reg <= (head_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : head_reg + PTR_W'(1);
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_bit_reg <= cell_alive;
            s1_col_reg <= col_reg;
        end
        if (push)
        begin
            fifo_reg[tail_reg] <= res_new;
        end
    end

    // result port
    assign result_valid      = (cnt_reg != '0);
    assign out_valid         = fifo_reg[head_reg].out_valid;
    assign next_alive        = fifo_reg[head_reg].next_alive;
    assign cell_changed      = fifo_reg[head_reg].cell_changed;
    assign frame_done        = fifo_reg[head_reg].frame_done;
    assign generation_stable = fifo_reg[head_reg].generation_stable;

endmodule

@@ rtl/lca_ram.sv @@
// ----------------------------------------------------------------------------
// lca_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module lca_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  logic                                 clk,
    input  logic                                 wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                     wr_data,
    input  logic                                 rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                     rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/lca_checker.sv @@
// ----------------------------------------------------------------------------
// lca_checker
// Port-level checks of the life rule stream stepper, bound to its top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lca_checker
    import lca_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             result_valid,
    input logic             result_ready,
    input logic             out_valid,
    input logic             next_alive,
    input logic             cell_changed,
    input logic             frame_done,
    input logic             generation_stable
);

    // a stable report only comes with the last cell of the frame
    `CHK_IMPLY(a_stable_at_end, clk, rst_n, result_valid && generation_stable, frame_done)

    // the last cell of a frame is always past the warm-up
    `CHK_IMPLY(a_end_is_emitted, clk, rst_n, result_valid && frame_done, out_valid)

    // warm-up items carry a dead, unchanged cell
    `CHK_IMPLY(a_warmup_dead, clk, rst_n, result_valid && !out_valid,
               !next_alive && !cell_changed)

    // a stalled result item holds
    `CHK_NEXT(a_result_held, clk, rst_n, result_valid && !result_ready,
              result_valid && $stable(out_valid) && $stable(next_alive) &&
              $stable(cell_changed) && $stable(frame_done) && $stable(generation_stable))

endmodule

bind life_cellular_automaton_step lca_checker u_lca_checker (.*);
